/* rtl/fsmc_pkg.sv */
package fsmc_pkg;

  localparam int DUTY_BITS = 8;

  typedef logic [DUTY_BITS-1:0] duty_t;
  typedef logic [1:0]           level_t;
  typedef logic signed [7:0]    temp_t;

  localparam temp_t TEMP_T1 = 8'sd22;
  localparam temp_t TEMP_T2 = 8'sd25;
  localparam temp_t TEMP_T3 = 8'sd27;
  localparam temp_t TEMP_T4 = 8'sd30;
  localparam temp_t TEMP_T5 = 8'sd33;

  localparam duty_t AUTO_D0 = DUTY_BITS'(0);
  localparam duty_t AUTO_D1 = DUTY_BITS'(70);
  localparam duty_t AUTO_D2 = DUTY_BITS'(100);
  localparam duty_t AUTO_D3 = DUTY_BITS'(130);
  localparam duty_t AUTO_D4 = DUTY_BITS'(170);
  localparam duty_t AUTO_D5 = DUTY_BITS'(200);

  localparam duty_t MAN_D0 = DUTY_BITS'(0);
  localparam duty_t MAN_D1 = DUTY_BITS'(60);
  localparam duty_t MAN_D2 = DUTY_BITS'(110);
  localparam duty_t MAN_D3 = DUTY_BITS'(180);

  function automatic duty_t level_duty(level_t lvl);
    duty_t d;
    case (lvl)
      2'd0:    d = MAN_D0;
      2'd1:    d = MAN_D1;
      2'd2:    d = MAN_D2;
      default: d = MAN_D3;
    endcase
    return d;
  endfunction

  function automatic duty_t auto_duty(temp_t t);
    duty_t d;
    if (t >= TEMP_T5) begin
      d = AUTO_D5;
    end else if (t >= TEMP_T4) begin
      d = AUTO_D4;
    end else if (t >= TEMP_T3) begin
      d = AUTO_D3;
    end else if (t >= TEMP_T2) begin
      d = AUTO_D2;
    end else if (t >= TEMP_T1) begin
      d = AUTO_D1;
    end else begin
      d = AUTO_D0;
    end
    return d;
  endfunction

endpackage

/* rtl/fan_speed_mode_controller.sv */
// Fan speed and mode controller. Each input word is one sample tick with two
// button flags and a signed temperature; each tick yields exactly one output
// word with the fan duty, a duty-changed flag, the mode and the speed level.
// A press counts when a flag is seen on two consecutive ticks after a
// release. One word is accepted every clock cycle while in_ready is high; a word
// passes an input register and then an output register, where its result is
// presented; a stall on the output side keeps it in the input register. While
// a result waits, the input register takes one more word, then in_ready drops
// until the output word is taken.
module fan_speed_mode_controller
  import fsmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 button_one_pressed,
  input  logic                 button_two_pressed,
  input  logic signed [7:0]    temperature,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_BITS-1:0] duty,
  output logic                 duty_changed,
  output logic                 auto_mode,
  output logic [1:0]           speed_level
);

  logic   s1_valid;
  logic   s1_b1;
  logic   s1_b2;
  temp_t  s1_temp;

  logic   mode_flag;
  level_t level_count;
  duty_t  last_duty;
  logic   one_prev;
  logic   one_wait;
  logic   two_prev;
  logic   two_wait;

  logic   s2_take;
  logic   s1_take;
  logic   one_hit;
  logic   two_hit;
  level_t level_step;
  level_t level_next;
  logic   mode_next;
  duty_t  duty_next;

  assign s2_take  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_take;
  assign s1_take  = in_valid && in_ready;

  always_comb begin
    one_hit    = !mode_flag && s1_b1 && one_prev && !one_wait;
    level_step = one_hit ? level_count + 2'd1 : level_count;
    two_hit    = s1_b2 && two_prev && !two_wait;
    mode_next  = mode_flag ^ two_hit;
    level_next = two_hit ? 2'd0 : level_step;
    duty_next  = mode_next ? auto_duty(s1_temp) : level_duty(level_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_take) begin
      s1_b1   <= button_one_pressed;
      s1_b2   <= button_two_pressed;
      s1_temp <= temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flag   <= 1'b0;
      level_count <= 2'd0;
      last_duty   <= '0;
      one_prev    <= 1'b0;
      one_wait    <= 1'b0;
      two_prev    <= 1'b0;
      two_wait    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (s2_take) begin
        mode_flag   <= mode_next;
        level_count <= level_next;
        last_duty   <= duty_next;
        one_prev    <= s1_b1;
        one_wait    <= s1_b1 && (one_wait || one_hit);
        two_prev    <= s1_b2;
        two_wait    <= s1_b2 && (two_wait || two_hit);
        out_valid   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      duty         <= duty_next;
      duty_changed <= duty_next != last_duty;
      auto_mode    <= mode_next;
      speed_level  <= level_next;
    end
  end

endmodule

/* rtl/fsmc_checker.sv */
module fsmc_checker
  import fsmc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DUTY_BITS-1:0] duty,
  input logic                 duty_changed,
  input logic                 auto_mode,
  input logic [1:0]           speed_level
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(duty_changed)
      && $stable(auto_mode) && $stable(speed_level))
    else $error("output word changed while stalled");

  a_manual_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !auto_mode |-> duty == level_duty(speed_level))
    else $error("manual duty does not match level");

  a_auto_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && auto_mode |-> speed_level == 2'd0)
    else $error("level not cleared in auto mode");

  a_auto_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && auto_mode |-> duty == AUTO_D0 || duty == AUTO_D1 || duty == AUTO_D2
      || duty == AUTO_D3 || duty == AUTO_D4 || duty == AUTO_D5)
    else $error("auto duty outside threshold table");

endmodule

bind fan_speed_mode_controller fsmc_checker u_fsmc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .duty         (duty),
  .duty_changed (duty_changed),
  .auto_mode    (auto_mode),
  .speed_level  (speed_level)
);
